// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the variance monitor.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define SWVM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define SWVM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWVM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/swvm_pkg.sv =====
// Package for the sliding window variance monitor: field widths, reset
// values, the window control struct and the sample magnitude helper.
// No dependencies.
package swvm_pkg;

  // Field widths
  localparam int unsigned SampleW    = 16;
  localparam int unsigned VarW       = 30;
  localparam int unsigned FillOutW   = 5;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 40;

  // Defaults
  localparam int unsigned DefaultWindowDepth = 16;
  localparam logic [VarW-1:0] ThrReset = VarW'(128);
  localparam logic [VarW-1:0] VarMax   = '1;

  // Window memory control
  typedef struct packed {
    logic rd;  // read the slot at the write position
    logic wr;  // write the slot and advance
  } ring_ctrl_t;

  // Magnitude of a sample; the most negative value maps to 2^(SampleW-1)
  function automatic logic [SampleW-1:0] abs_sample(logic signed [SampleW-1:0] x);
    logic [SampleW-1:0] r;
    r = x[SampleW-1] ? SampleW'(-x) : SampleW'(x);
    return r;
  endfunction

endpackage

// ===== src/swvm_serial_mult.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on swvm_pkg for its default width.
module swvm_serial_mult #(
  parameter int unsigned Width = swvm_pkg::SampleW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [Width-1:0]   a_i,
  input  logic [Width-1:0]   b_i,
  output logic               done_o,
  output logic [2*Width-1:0] prod_o
);
  import swvm_pkg::*;

  localparam int unsigned CntW = $clog2(Width + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [Width-1:0]   a_q;
  logic [2*Width-1:0] p_q;
  logic [Width:0]     step_sum;

  // Add the multiplicand into the upper half when the current bit is set
  assign step_sum = {1'b0, p_q[2*Width-1:Width]} + (p_q[0] ? {1'b0, a_q} : '0);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Product shift register; low half starts with the multiplier
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{Width{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {step_sum, p_q[Width-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ===== src/swvm_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on swvm_pkg for its default widths.
module swvm_serial_div #(
  parameter int unsigned DividendW = 2 * swvm_pkg::SampleW,
  parameter int unsigned DivisorW  = swvm_pkg::FillOutW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quot_o
);
  import swvm_pkg::*;

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DivisorW-1:0]  d_q;
  logic [DivisorW-1:0]  r_q;
  logic [DividendW-1:0] q_q;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    trial_diff;
  logic                 fits;

  // Bring down the next dividend bit and try a subtract
  assign trial      = {r_q, q_q[DividendW-1]};
  assign trial_diff = trial - {1'b0, d_q};
  assign fits       = (trial >= {1'b0, d_q});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DividendW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= divisor_i;
      r_q <= '0;
      q_q <= dividend_i;
    end else if (busy_q) begin
      r_q <= fits ? trial_diff[DivisorW-1:0] : trial[DivisorW-1:0];
      q_q <= {q_q[DividendW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== src/swvm_ring.sv =====
// Sample window: ring memory with registered read, write position and
// fill count. Depends on swvm_pkg for the control struct.
module swvm_ring #(
  parameter int unsigned Depth = swvm_pkg::DefaultWindowDepth,
  parameter int unsigned Width = swvm_pkg::SampleW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  swvm_pkg::ring_ctrl_t       ctrl_i,
  input  logic [Width-1:0]           wr_data_i,
  output logic [Width-1:0]           rd_data_o,
  output logic [$clog2(Depth+1)-1:0] fill_o
);
  import swvm_pkg::*;

  localparam int unsigned PosW  = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;
  logic [PosW-1:0]  pos_q;
  logic [FillW-1:0] fill_q;
  logic             full;

  assign full = (fill_q == FillW'(Depth));

  // Memory: one port, read of the oldest slot before it is overwritten
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[pos_q] <= wr_data_i;
    end
    if (ctrl_i.rd) begin
      rd_data_q <= mem_q[pos_q];
    end
  end

  // Write position and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else if (ctrl_i.wr) begin
      pos_q <= (pos_q == PosW'(Depth - 1)) ? '0 : pos_q + 1'b1;
      if (!full) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign fill_o    = fill_q;

endmodule

// ===== src/sliding_window_variance_monitor_unit.sv =====
// Sliding window variance monitor: one signed Q11.4 sample in, one result
// item out with the population variance (unsigned Q.8), a threshold flag and
// the fill level. One item is in work at a time; the bit-serial squarers,
// the bit-serial mean divider and the squarer of the mean run in series,
// the divider being sum width = 17 + log2(window) bits long. The result
// becomes valid in the same cycle as the next item can be taken, and
// waits in the output register while the next item is taken.
// Depends on swvm_pkg, swvm_ring, swvm_serial_mult, swvm_serial_div.
`include "assert_macros.svh"

module sliding_window_variance_monitor_unit #(
  parameter int unsigned WindowDepth = swvm_pkg::DefaultWindowDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swvm_pkg::InDataW-1:0]  s_axis_tdata,  // [15:0] sample
  // Result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [swvm_pkg::OutDataW-1:0] m_axis_tdata,  // [29:0] variance,
                                                        // [30] fluctuating,
                                                        // [35:31] fill_level,
                                                        // [39:36] zero
  // Threshold register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swvm_pkg::VarW-1:0]     cfg_data_i
);
  import swvm_pkg::*;

  localparam int unsigned FillW = $clog2(WindowDepth + 1);
  localparam int unsigned SumW  = SampleW + $clog2(WindowDepth) + 1;
  localparam int unsigned SqW   = 2 * SampleW - 1 + $clog2(WindowDepth);
  localparam int unsigned ProdW = 2 * SampleW;
  localparam int unsigned PadW  = OutDataW - VarW - 1 - FillOutW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SQ,
    S_DIV_GO,
    S_DIV,
    S_FIN
  } state_e;

  state_e                      state_q;
  logic signed [SampleW-1:0]   sample_q;
  logic signed [SumW-1:0]      sum_q;
  logic [SqW-1:0]              sqsum_q;
  logic [VarW-1:0]             thr_q;
  logic                        m2_ok_q;
  logic                        msq_ok_q;
  logic                        out_valid_q;
  logic [OutDataW-1:0]         out_data_q;

  logic                        in_accept;
  ring_ctrl_t                  ring_ctrl;
  logic [SampleW-1:0]          ring_rd;
  logic [FillW-1:0]            ring_fill;
  logic                        ring_full;
  logic signed [SampleW-1:0]   old_s;

  logic                        mula_start;
  logic [SampleW-1:0]          mula_op;
  logic                        mula_done;
  logic [ProdW-1:0]            mula_prod;
  logic                        mulb_start;
  logic [SampleW-1:0]          mulb_op;
  logic                        mulb_done;
  logic [ProdW-1:0]            mulb_prod;

  logic                        div_start;
  logic [SumW-1:0]             sum_abs;
  logic                        divs_done;
  logic [SumW-1:0]             divs_quot;
  logic                        divq_done;
  logic [SqW-1:0]              divq_quot;

  logic signed [SumW-1:0]      sum_next;
  logic [SqW-1:0]              sq_next;
  logic [SqW-1:0]              m2_ext;
  logic [SqW-1:0]              var_full;
  logic [VarW-1:0]             var_res;
  logic                        flag_res;
  logic                        out_free;
  logic                        out_load;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Window memory: read the oldest slot on accept, write once the squares are in
  assign ring_ctrl.rd = in_accept;
  assign ring_ctrl.wr = (state_q == S_SQ) && mula_done;
  assign ring_full    = (ring_fill == FillW'(WindowDepth));
  assign old_s        = ring_full ? ring_rd : '0;

  swvm_ring #(
    .Depth (WindowDepth),
    .Width (SampleW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ring_ctrl),
    .wr_data_i (sample_q),
    .rd_data_o (ring_rd),
    .fill_o    (ring_fill)
  );

  // Squarer A: new sample, then the mean; squarer B: dropped sample
  assign mula_start = (state_q == S_READ) || ((state_q == S_DIV) && divs_done);
  assign mula_op    = (state_q == S_READ) ? abs_sample(sample_q)
                                          : divs_quot[SampleW-1:0];
  assign mulb_start = (state_q == S_READ);
  assign mulb_op    = abs_sample(old_s);

  swvm_serial_mult #(
    .Width (SampleW)
  ) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mula_start),
    .a_i     (mula_op),
    .b_i     (mula_op),
    .done_o  (mula_done),
    .prod_o  (mula_prod)
  );

  swvm_serial_mult #(
    .Width (SampleW)
  ) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mulb_start),
    .a_i     (mulb_op),
    .b_i     (mulb_op),
    .done_o  (mulb_done),
    .prod_o  (mulb_prod)
  );

  // Running sums after dropping the oldest and adding the new sample
  assign sum_next = sum_q - SumW'(old_s) + SumW'(sample_q);
  assign sq_next  = sqsum_q - SqW'(mulb_prod) + SqW'(mula_prod);

  // Mean magnitude and mean square, both truncated
  assign div_start = (state_q == S_DIV_GO);
  assign sum_abs   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  swvm_serial_div #(
    .DividendW (SumW),
    .DivisorW  (FillW)
  ) u_div_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs),
    .divisor_i  (ring_fill),
    .done_o     (divs_done),
    .quot_o     (divs_quot)
  );

  swvm_serial_div #(
    .DividendW (SqW),
    .DivisorW  (FillW)
  ) u_div_sq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sqsum_q),
    .divisor_i  (ring_fill),
    .done_o     (divq_done),
    .quot_o     (divq_quot)
  );

  // Variance: clamp at zero, saturate, zero for at most one sample
  assign m2_ext   = SqW'(mula_prod);
  assign var_full = (divq_quot > m2_ext) ? (divq_quot - m2_ext) : '0;
  always_comb begin
    if (ring_fill <= FillW'(1)) begin
      var_res = '0;
    end else if (var_full > SqW'(VarMax)) begin
      var_res = VarMax;
    end else begin
      var_res = var_full[VarW-1:0];
    end
  end
  assign flag_res = (var_res > thr_q);

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == S_FIN) && out_free;

  // Sequencer, running sums, threshold and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      sqsum_q     <= '0;
      thr_q       <= ThrReset;
      m2_ok_q     <= 1'b0;
      msq_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (mula_done) begin
            sum_q   <= sum_next;
            sqsum_q <= sq_next;
            state_q <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          m2_ok_q  <= 1'b0;
          msq_ok_q <= 1'b0;
          state_q  <= S_DIV;
        end
        S_DIV: begin
          if (mula_done) begin
            m2_ok_q <= 1'b1;
          end
          if (divq_done) begin
            msq_ok_q <= 1'b1;
          end
          if (m2_ok_q && msq_ok_q) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= s_axis_tdata[SampleW-1:0];
    end
    if (out_load) begin
      out_data_q <= {{PadW{1'b0}}, FillOutW'(ring_fill), flag_res, var_res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `SWVM_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, ring_fill > FillW'(WindowDepth), "window fill above depth")
  `SWVM_ASSERT(a_fin_ready, clk_i, rst_ni, (state_q == S_FIN) |-> (m2_ok_q && msq_ok_q), "result formed before both means")
  `SWVM_ASSERT(a_small_zero, clk_i, rst_ni, (out_load && ring_fill <= FillW'(1)) |=> (m_axis_tdata[VarW:0] == '0), "nonzero variance for one sample")
  `SWVM_ASSERT(a_flag_thr, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[VarW]) |-> (m_axis_tdata[VarW-1:0] > thr_q), "flag without variance above threshold")
  `SWVM_ASSERT(a_mul_lockstep, clk_i, rst_ni, (state_q == S_SQ) |-> (mula_done == mulb_done), "squarers out of step")

endmodule
